// ===== rtl/quadratic_root_solver_assert.svh =====
// Assertion macros used by the checker file of the quadratic root solver.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// Same-cycle implication, sampled at the rising clock edge, off during reset.
`define QRS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quadratic_root_solver: assertion failed");

// Next-cycle implication, sampled at the rising clock edge, off during reset.
`define QRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quadratic_root_solver: assertion failed");

`endif

// ===== rtl/qrs_pkg.sv =====
// Package of the quadratic root solver: widths, root class codes and payload types.
// Used by every module of the block but qrs_div; depends on nothing.
package qrs_pkg;

    localparam int DATA_WIDTH        = 32;
    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int DISC_W            = 2 * DATA_WIDTH + 2;
    localparam int QUEUE_DEPTH       = 4;

    typedef enum logic [2:0] {
        CLS_TWO    = 3'd0,
        CLS_DOUBLE = 3'd1,
        CLS_NONE   = 3'd2,
        CLS_LINEAR = 3'd3,
        CLS_DEGEN  = 3'd4
    } root_class_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] coef_a;
        logic signed [DATA_WIDTH-1:0] coef_b;
        logic signed [DATA_WIDTH-1:0] coef_c;
    } coef_t;

    typedef struct packed {
        root_class_t                  root_class;
        logic signed [DATA_WIDTH-1:0] root_one;
        logic signed [DATA_WIDTH-1:0] root_two;
        logic                         saturated;
    } roots_t;

    // A classified item as it travels from the front to the back.
    typedef struct packed {
        root_class_t                  cls;
        logic signed [DATA_WIDTH-1:0] a;
        logic signed [DATA_WIDTH-1:0] b;
        logic signed [DATA_WIDTH-1:0] c;
        logic [DISC_W-1:0]            disc;
    } qent_t;

endpackage

// ===== rtl/qrs_front.sv =====
// Front of the quadratic root solver: accepts coefficients, forms the discriminant
// and classifies the item. Depends on qrs_pkg.
module qrs_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           coef_valid,
    output logic           coef_ready,
    input  qrs_pkg::coef_t coef,
    output logic           ent_valid,
    input  logic           ent_ready,
    output qrs_pkg::qent_t ent
);

    localparam int DW     = qrs_pkg::DATA_WIDTH;
    localparam int DISC_W = qrs_pkg::DISC_W;

    logic                 s1_valid_reg;
    logic                 s2_valid_reg;
    logic signed [DW-1:0] s1_a_reg;
    logic signed [DW-1:0] s1_b_reg;
    logic signed [DW-1:0] s1_c_reg;
    logic [2*DW-1:0]      s1_bb_reg;
    logic [2*DW-1:0]      s1_ac_reg;
    qrs_pkg::qent_t       ent_reg;
    qrs_pkg::qent_t       ent_next;

    logic                 adv;
    logic [DW-1:0]        mag_a;
    logic [DW-1:0]        mag_b;
    logic [DW-1:0]        mag_c;
    logic [DISC_W-1:0]    bb_x;
    logic [DISC_W-1:0]    ac4;
    logic [DISC_W-1:0]    sum;
    logic                 ac_neg;
    logic                 gt;
    logic                 eq;

    // Both stages move together whenever the last one is free or drains.
    assign adv        = !s2_valid_reg || ent_ready;
    assign coef_ready = adv;
    assign ent_valid  = s2_valid_reg;
    assign ent        = ent_reg;

    // Magnitudes of the coefficients for the unsigned products.
    always_comb
    begin
        mag_a = coef.coef_a[DW-1] ? (~coef.coef_a + 1'b1) : coef.coef_a;
        mag_b = coef.coef_b[DW-1] ? (~coef.coef_b + 1'b1) : coef.coef_b;
        mag_c = coef.coef_c[DW-1] ? (~coef.coef_c + 1'b1) : coef.coef_c;
    end

    // Discriminant and class from the registered products.
    always_comb
    begin
        bb_x   = {2'b00, s1_bb_reg};
        ac4    = {s1_ac_reg, 2'b00};
        sum    = bb_x + ac4;
        ac_neg = (s1_a_reg[DW-1] != s1_c_reg[DW-1]) && (s1_c_reg != '0);
        gt     = bb_x > ac4;
        eq     = bb_x == ac4;

        ent_next.a = s1_a_reg;
        ent_next.b = s1_b_reg;
        ent_next.c = s1_c_reg;
        if (ac_neg)
        begin
            ent_next.disc = sum;
        end
        else if (gt)
        begin
            ent_next.disc = bb_x - ac4;
        end
        else
        begin
            ent_next.disc = bb_x;
        end

        if (s1_a_reg == '0)
        begin
            ent_next.cls = (s1_b_reg == '0) ? qrs_pkg::CLS_DEGEN : qrs_pkg::CLS_LINEAR;
        end
        else if (ac_neg || gt)
        begin
            ent_next.cls = qrs_pkg::CLS_TWO;
        end
        else if (eq)
        begin
            ent_next.cls = qrs_pkg::CLS_DOUBLE;
        end
        else
        begin
            ent_next.cls = qrs_pkg::CLS_NONE;
        end
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= coef_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage payloads: products in the first stage, classified item in the second.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_a_reg  <= coef.coef_a;
            s1_b_reg  <= coef.coef_b;
            s1_c_reg  <= coef.coef_c;
            s1_bb_reg <= mag_b * mag_b;
            s1_ac_reg <= mag_a * mag_c;
            ent_reg   <= ent_next;
        end
    end

endmodule

// ===== rtl/qrs_queue.sv =====
// Short queue of classified items between the front and the back.
// Depends on qrs_pkg for the item type and the depth.
module qrs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  qrs_pkg::qent_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output qrs_pkg::qent_t pop_data
);

    localparam int DEPTH = qrs_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    qrs_pkg::qent_t slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           push;
    logic           pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Item storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/qrs_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for the root quotients.
// Self-contained; the enable comes from the back of the quadratic root solver.
module qrs_div #(
    parameter int NUM_W = 51,
    parameter int DEN_W = 33
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic             neg_in,
    output logic [NUM_W-1:0] quo,
    output logic             neg_out
);

    logic [NUM_W-1:0] numsh_reg [NUM_W];
    logic [DEN_W-1:0] rem_reg   [NUM_W];
    logic [NUM_W-1:0] q_reg     [NUM_W];
    logic [DEN_W-1:0] den_reg   [NUM_W];
    logic             neg_reg   [NUM_W];

    assign quo     = q_reg[NUM_W-1];
    assign neg_out = neg_reg[NUM_W-1];

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        logic [NUM_W-1:0] numsh_in;
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] q_in;
        logic [DEN_W-1:0] den_in;
        logic             neg_i;
        logic [DEN_W:0]   r2;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign numsh_in = num;
            assign rem_in   = '0;
            assign q_in     = '0;
            assign den_in   = den;
            assign neg_i    = neg_in;
        end
        else
        begin : g_rest
            assign numsh_in = numsh_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign q_in     = q_reg[k-1];
            assign den_in   = den_reg[k-1];
            assign neg_i    = neg_reg[k-1];
        end

        // Bring down one numerator bit and try the subtraction.
        always_comb
        begin
            r2   = {rem_in, numsh_in[NUM_W-1]};
            diff = r2 - {1'b0, den_in};
            ge   = r2 >= {1'b0, den_in};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                numsh_reg[k] <= {numsh_in[NUM_W-2:0], 1'b0};
                rem_reg[k]   <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
                q_reg[k]     <= {q_in[NUM_W-2:0], ge};
                den_reg[k]   <= den_in;
                neg_reg[k]   <= neg_i;
            end
        end
    end

endmodule

// ===== rtl/qrs_back.sv =====
// Back of the quadratic root solver: square root, quotient set-up, two dividers
// and the clamped output register. Depends on qrs_pkg and qrs_div.
module qrs_back #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            ent_valid,
    output logic            ent_ready,
    input  qrs_pkg::qent_t  ent,
    output logic            root_valid,
    input  logic            root_ready,
    output qrs_pkg::roots_t root
);

    localparam int DW     = qrs_pkg::DATA_WIDTH;
    localparam int SW     = DW + 1;
    localparam int DISC_W = 2 * SW;
    localparam int RW     = SW + 3;
    localparam int NSW    = DW + 3;
    localparam int UW     = DW + 2;
    localparam int DENW   = DW + 1;
    localparam int NW     = UW + FRAC_BITS + 1;
    localparam int VL     = SW + 3 + NW + 1;
    localparam logic [NW-1:0] LIM_NEG = NW'(1) << (DW - 1);
    localparam logic [NW-1:0] LIM_POS = LIM_NEG - NW'(1);

    typedef struct packed {
        qrs_pkg::root_class_t cls;
        logic signed [DW-1:0] a;
        logic signed [DW-1:0] b;
        logic signed [DW-1:0] c;
    } item_t;

    logic                 adv;
    logic [VL-1:0]        vld_reg;

    item_t                sq_item_reg [SW];
    logic [DISC_W-1:0]    sq_d_reg    [SW];
    logic [RW-1:0]        sq_rem_reg  [SW];
    logic [SW-1:0]        sq_root_reg [SW];

    qrs_pkg::root_class_t p1_cls_reg;
    logic signed [NSW-1:0] p1_n1_reg;
    logic signed [NSW-1:0] p1_n2_reg;
    logic signed [NSW-1:0] p1_den_reg;
    qrs_pkg::root_class_t p2_cls_reg;
    logic [UW-1:0]        p2_un1_reg;
    logic [UW-1:0]        p2_un2_reg;
    logic [DENW-1:0]      p2_ud_reg;
    logic                 p2_neg1_reg;
    logic                 p2_neg2_reg;
    qrs_pkg::root_class_t p3_cls_reg;
    logic [NW-1:0]        p3_num1_reg;
    logic [NW-1:0]        p3_num2_reg;
    logic [DENW-1:0]      p3_ud_reg;
    logic                 p3_neg1_reg;
    logic                 p3_neg2_reg;
    qrs_pkg::root_class_t div_cls_reg [NW];
    qrs_pkg::roots_t      root_reg;
    qrs_pkg::roots_t      root_next;

    item_t                 it_end;
    logic signed [NSW-1:0] sx;
    logic signed [NSW-1:0] nb;
    logic signed [NSW-1:0] n1_next;
    logic signed [NSW-1:0] n2_next;
    logic signed [NSW-1:0] den_next;
    logic [NSW-1:0]        mag1;
    logic [NSW-1:0]        mag2;
    logic [NSW-1:0]        magd;
    logic [NW-1:0]         q1;
    logic [NW-1:0]         q2;
    logic                  qn1;
    logic                  qn2;
    logic [NW-1:0]         lim1;
    logic [NW-1:0]         lim2;
    logic                  ovf1;
    logic                  ovf2;
    logic [DW-1:0]         v1;
    logic [DW-1:0]         v2;
    logic [DW-1:0]         r1;
    logic [DW-1:0]         r2;

    function automatic logic [NSW-1:0] mag_f(input logic signed [NSW-1:0] v);
        logic [NSW-1:0] m;
        m = v[NSW-1] ? (~v + 1'b1) : v;
        return m;
    endfunction

    // The whole pipeline moves unless the output holds an item not yet taken.
    assign adv        = !vld_reg[VL-1] || root_ready;
    assign ent_ready  = adv;
    assign root_valid = vld_reg[VL-1];
    assign root       = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[VL-2:0], ent_valid};
        end
    end

    // Square root of the discriminant, one root bit per stage.
    for (genvar k = 0; k < SW; k++)
    begin : g_sqrt
        item_t             it_in;
        logic [DISC_W-1:0] d_in;
        logic [RW-1:0]     rem_in;
        logic [SW-1:0]     root_in;
        logic [RW-1:0]     rem_sh;
        logic [RW-1:0]     trial;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign it_in   = '{cls: ent.cls, a: ent.a, b: ent.b, c: ent.c};
            assign d_in    = ent.disc;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign it_in   = sq_item_reg[k-1];
            assign d_in    = sq_d_reg[k-1];
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
        end

        always_comb
        begin
            rem_sh = {rem_in[RW-3:0], d_in[DISC_W-1 -: 2]};
            trial  = {1'b0, root_in, 2'b01};
            ge     = rem_sh >= trial;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_item_reg[k] <= it_in;
                sq_d_reg[k]    <= {d_in[DISC_W-3:0], 2'b00};
                sq_rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
                sq_root_reg[k] <= {root_in[SW-2:0], ge};
            end
        end
    end

    // Signed numerators and denominator for each class.
    always_comb
    begin
        it_end   = sq_item_reg[SW-1];
        sx       = $signed({2'b00, sq_root_reg[SW-1]});
        nb       = -NSW'(it_end.b);
        n1_next  = '0;
        n2_next  = '0;
        den_next = NSW'(it_end.a) <<< 1;
        case (it_end.cls)
            qrs_pkg::CLS_TWO:
            begin
                n1_next = nb + sx;
                n2_next = nb - sx;
            end
            qrs_pkg::CLS_DOUBLE:
            begin
                n1_next = nb;
            end
            qrs_pkg::CLS_LINEAR:
            begin
                n1_next  = -NSW'(it_end.c);
                den_next = NSW'(it_end.b);
            end
            default:
            begin
                n1_next = '0;
            end
        endcase
    end

    // Magnitudes and result signs.
    always_comb
    begin
        mag1 = mag_f(p1_n1_reg);
        mag2 = mag_f(p1_n2_reg);
        magd = mag_f(p1_den_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_cls_reg  <= it_end.cls;
            p1_n1_reg   <= n1_next;
            p1_n2_reg   <= n2_next;
            p1_den_reg  <= den_next;

            p2_cls_reg  <= p1_cls_reg;
            p2_un1_reg  <= mag1[UW-1:0];
            p2_un2_reg  <= mag2[UW-1:0];
            p2_ud_reg   <= magd[DENW-1:0];
            p2_neg1_reg <= p1_n1_reg[NSW-1] ^ p1_den_reg[NSW-1];
            p2_neg2_reg <= p1_n2_reg[NSW-1] ^ p1_den_reg[NSW-1];

            // Scaled numerator plus half the divisor rounds the quotient.
            p3_cls_reg  <= p2_cls_reg;
            p3_num1_reg <= NW'({p2_un1_reg, {FRAC_BITS{1'b0}}}) + NW'(p2_ud_reg >> 1);
            p3_num2_reg <= NW'({p2_un2_reg, {FRAC_BITS{1'b0}}}) + NW'(p2_ud_reg >> 1);
            p3_ud_reg   <= p2_ud_reg;
            p3_neg1_reg <= p2_neg1_reg;
            p3_neg2_reg <= p2_neg2_reg;

            div_cls_reg[0] <= p3_cls_reg;
            for (int i = 1; i < NW; i++)
            begin
                div_cls_reg[i] <= div_cls_reg[i-1];
            end

            root_reg <= root_next;
        end
    end

    qrs_div #(
        .NUM_W (NW),
        .DEN_W (DENW)
    ) u_div_one (
        .clk     (clk),
        .en      (adv),
        .num     (p3_num1_reg),
        .den     (p3_ud_reg),
        .neg_in  (p3_neg1_reg),
        .quo     (q1),
        .neg_out (qn1)
    );

    qrs_div #(
        .NUM_W (NW),
        .DEN_W (DENW)
    ) u_div_two (
        .clk     (clk),
        .en      (adv),
        .num     (p3_num2_reg),
        .den     (p3_ud_reg),
        .neg_in  (p3_neg2_reg),
        .quo     (q2),
        .neg_out (qn2)
    );

    // Clamp, restore the sign and pick the fields that the class reports.
    always_comb
    begin
        lim1 = qn1 ? LIM_NEG : LIM_POS;
        lim2 = qn2 ? LIM_NEG : LIM_POS;
        ovf1 = q1 > lim1;
        ovf2 = q2 > lim2;
        v1   = ovf1 ? lim1[DW-1:0] : q1[DW-1:0];
        v2   = ovf2 ? lim2[DW-1:0] : q2[DW-1:0];
        r1   = qn1 ? (~v1 + 1'b1) : v1;
        r2   = qn2 ? (~v2 + 1'b1) : v2;

        root_next.root_class = div_cls_reg[NW-1];
        root_next.root_one   = '0;
        root_next.root_two   = '0;
        root_next.saturated  = 1'b0;
        case (div_cls_reg[NW-1])
            qrs_pkg::CLS_TWO:
            begin
                root_next.root_one  = r1;
                root_next.root_two  = r2;
                root_next.saturated = ovf1 | ovf2;
            end
            qrs_pkg::CLS_DOUBLE, qrs_pkg::CLS_LINEAR:
            begin
                root_next.root_one  = r1;
                root_next.saturated = ovf1;
            end
            default:
            begin
                root_next.saturated = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/quadratic_root_solver.sv =====
// Quadratic root solver: one coefficient item per cycle while coef_ready is high,
// one result per item. Path at Q16.16: two front stages, the queue, one square root
// stage per root bit, three set-up stages, one divider stage per quotient bit and
// the output register. Throughput is one item per cycle unless root_ready stalls
// the output. Reset clears all valid flags and queue pointers; no payload is reset.
module quadratic_root_solver #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            coef_valid,
    output logic            coef_ready,
    input  qrs_pkg::coef_t  coef,
    output logic            root_valid,
    input  logic            root_ready,
    output qrs_pkg::roots_t root
);

    logic           fr_valid;
    logic           fr_ready;
    qrs_pkg::qent_t fr_ent;
    logic           bk_valid;
    logic           bk_ready;
    qrs_pkg::qent_t bk_ent;

    // Classify, queue, then solve.
    qrs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef_valid (coef_valid),
        .coef_ready (coef_ready),
        .coef       (coef),
        .ent_valid  (fr_valid),
        .ent_ready  (fr_ready),
        .ent        (fr_ent)
    );

    qrs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_data  (fr_ent),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_data   (bk_ent)
    );

    qrs_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ent_valid  (bk_valid),
        .ent_ready  (bk_ready),
        .ent        (bk_ent),
        .root_valid (root_valid),
        .root_ready (root_ready),
        .root       (root)
    );

endmodule

// ===== rtl/qrs_checker.sv =====
// Port-level checks of the quadratic root solver's result channel, bound to the top.
// Depends on qrs_pkg and quadratic_root_solver_assert.svh.
`include "quadratic_root_solver_assert.svh"

module qrs_port_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            root_valid,
    input logic            root_ready,
    input qrs_pkg::roots_t root
);

    logic no_root_cls;
    logic zero_roots;
    logic solved_cls;

    // Class groups and the all-zero result shape.
    assign no_root_cls = (root.root_class == qrs_pkg::CLS_NONE)
                      || (root.root_class == qrs_pkg::CLS_DEGEN);
    assign zero_roots  = (root.root_one == '0) && (root.root_two == '0) && !root.saturated;
    assign solved_cls  = (root.root_class == qrs_pkg::CLS_TWO)
                      || (root.root_class == qrs_pkg::CLS_DOUBLE)
                      || (root.root_class == qrs_pkg::CLS_LINEAR);

    // A stalled result item holds.
    `QRS_ASSERT_NEXT(a_out_hold, root_valid && !root_ready, root_valid && $stable(root))

    // Classes without a root report zeros and no clamp.
    `QRS_ASSERT_IMPL(a_no_root_zero, root_valid && no_root_cls, zero_roots)

    // Only the two-root class fills the second root.
    `QRS_ASSERT_IMPL(a_second_root, root_valid && root.root_class != qrs_pkg::CLS_TWO, root.root_two == '0)

    // A clamp is only reported where a root was computed.
    `QRS_ASSERT_IMPL(a_sat_class, root_valid && root.saturated, solved_cls)

endmodule

bind quadratic_root_solver qrs_port_checker u_qrs_checker (.*);

// ===== test/qrs_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the quadratic root solver: predicts each result from the accepted items.
// Depends on qrs_pkg for the payload types and root class codes.
module qrs_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            coef_valid,
    input  logic            coef_ready,
    input  qrs_pkg::coef_t  coef,
    input  logic            root_valid,
    input  logic            root_ready,
    input  qrs_pkg::roots_t root,
    output int              mismatches,
    output int              pending
);
    import qrs_pkg::*;

    localparam int FB = FRAC_BITS_DEFAULT;
    localparam logic [127:0] HALF_SPAN = 128'd1 << (DATA_WIDTH - 1);

    roots_t expected_roots[$];

    // Rounded fixed-point quotient num * 2^FB / den, clamped to the output range.
    function automatic logic [DATA_WIDTH-1:0] fixed_quotient(input longint num,
                                                             input longint den,
                                                             inout bit clamped);
        bit neg;
        logic [127:0] un, ud, q, lim;
        logic [DATA_WIDTH-1:0] v;
        neg = (num < 0) != (den < 0);
        un = (num < 0) ? 128'(-num) : 128'(num);
        ud = (den < 0) ? 128'(-den) : 128'(den);
        lim = neg ? HALF_SPAN : HALF_SPAN - 1;
        q = ((un << FB) + (ud >> 1)) / ud;
        if (q > lim) begin
            q = lim;
            clamped = 1'b1;
        end
        v = q[DATA_WIDTH-1:0];
        if (neg) v = -v;
        return v;
    endfunction

    // Floor square root of a discriminant that fits well inside 2^102.
    function automatic longint floor_sqrt(input logic [127:0] d);
        logic [127:0] r, t;
        r = 0;
        for (int k = 50; k >= 0; k--) begin
            t = r | (128'd1 << k);
            if (t * t <= d) r = t;
        end
        return longint'(r);
    endfunction

    // Works out the class and roots of one coefficient item.
    function automatic roots_t solve_roots(input coef_t x);
        roots_t o;
        longint a, b, c, s;
        logic [127:0] bb, ac4, disc;
        bit clamped;
        a = x.coef_a;
        b = x.coef_b;
        c = x.coef_c;
        clamped = 0;
        o = '0;
        if (a == 0) begin
            if (b == 0) o.root_class = CLS_DEGEN;
            else begin
                o.root_class = CLS_LINEAR;
                o.root_one = fixed_quotient(-c, b, clamped);
            end
        end else begin
            bb = 128'((b < 0) ? -b : b) * 128'((b < 0) ? -b : b);
            ac4 = (128'((a < 0) ? -a : a) * 128'((c < 0) ? -c : c)) << 2;
            if ((a < 0) != (c < 0) && c != 0) disc = bb + ac4;
            else if (bb > ac4) disc = bb - ac4;
            else disc = 0;
            if (disc != 0) begin
                s = floor_sqrt(disc);
                o.root_class = CLS_TWO;
                o.root_one = fixed_quotient(-b + s, 2 * a, clamped);
                o.root_two = fixed_quotient(-b - s, 2 * a, clamped);
            end else if (bb == ac4) begin
                o.root_class = CLS_DOUBLE;
                o.root_one = fixed_quotient(-b, 2 * a, clamped);
            end else begin
                o.root_class = CLS_NONE;
            end
        end
        o.saturated = clamped;
        return o;
    endfunction

    assign pending = expected_roots.size();

    // Queue the prediction for each accepted item and compare each accepted result.
    always @(posedge clk or negedge rst_n) begin
        roots_t want;
        if (!rst_n) begin
            mismatches <= 0;
        end else begin
            if (coef_valid && coef_ready) expected_roots.push_back(solve_roots(coef));
            if (root_valid && root_ready) begin
                if (expected_roots.size() == 0) begin
                    if (mismatches < 10) $display("unexpected result %p", root);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_roots.pop_front();
                    if (want.root_class !== root.root_class || want.root_one !== root.root_one
                        || want.root_two !== root.root_two
                        || want.saturated !== root.saturated) begin
                        if (mismatches < 10)
                            $display("mismatch: expected %p, got %p", want, root);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the quadratic root solver test: clock, reset, coefficient items and verdict.
// Depends on qrs_pkg, quadratic_root_solver and qrs_checker.
module testbench;
    import qrs_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT  = 400000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    coef_valid = 1'b0;
    logic    coef_ready;
    coef_t   coef = '0;
    logic    root_valid;
    logic    root_ready = 1'b0;
    roots_t  root;
    int      mismatches;
    int      pending;
    int      idle_pct = 0;
    int      stall_pct = 0;
    int      cycles = 0;

    quadratic_root_solver u_dut (
        .clk(clk), .rst_n(rst_n), .coef_valid(coef_valid), .coef_ready(coef_ready),
        .coef(coef), .root_valid(root_valid), .root_ready(root_ready), .root(root)
    );

    qrs_checker u_checker (
        .clk(clk), .rst_n(rst_n), .coef_valid(coef_valid), .coef_ready(coef_ready),
        .coef(coef), .root_valid(root_valid), .root_ready(root_ready), .root(root),
        .mismatches(mismatches), .pending(pending)
    );

    always #10 clk = ~clk;

    // Receiver back-pressure at the current stall rate.
    always @(posedge clk) root_ready <= ($urandom_range(99) >= stall_pct);

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Offers one item, with random idle cycles first, and waits until it is taken.
    task automatic offer_item(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c);
        while ($urandom_range(99) < idle_pct) begin
            coef_valid <= 1'b0;
            @(posedge clk);
        end
        coef_valid <= 1'b1;
        coef <= '{coef_a: a, coef_b: b, coef_c: c};
        @(posedge clk);
        while (!coef_ready) @(posedge clk);
    endtask

    // Random value: full range, a small magnitude, an extreme, zero or a small whole number.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0, 1: return $urandom;
            2: return $urandom_range(1 << 20) - (1 << 19);
            3: return ($urandom_range(1) ? 32'h7fffffff : 32'h80000000) - $urandom_range(2);
            4: return 0;
            default: return ($urandom_range(40) - 20) << 16;
        endcase
    endfunction

    // Coefficients of a*(x - p)*(x - q) with small integer roots, so double roots occur.
    task automatic offer_factored();
        longint k, p, q;
        k = longint'($urandom_range(16)) - 8;
        if (k == 0) k = 1;
        p = longint'($urandom_range(20)) - 10;
        q = $urandom_range(3) == 0 ? p : longint'($urandom_range(20)) - 10;
        offer_item(32'(k << 16), 32'((-k * (p + q)) << 16), 32'((k * p * q) << 16));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every root class, linear and degenerate cases.
        offer_item(0, 0, 0);
        offer_item(0, 0, 32'h7fffffff);
        offer_item(0, 32'h00010000, 32'h00050000);
        offer_item(0, 32'hffff0000, 32'h80000000);
        offer_item(0, 32'h00000001, 32'h7fffffff);
        offer_item(0, 32'h80000000, 32'h80000000);
        offer_item(32'h00010000, 0, 32'hfffc0000);
        offer_item(32'h00010000, 32'hfffe0000, 32'h00010000);
        offer_item(32'h00010000, 0, 32'h00010000);
        offer_item(32'h80000000, 32'h80000000, 32'h80000000);
        offer_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        offer_item(32'h80000000, 32'h7fffffff, 32'h7fffffff);
        offer_item(32'h00000001, 32'h7fffffff, 32'h80000000);
        offer_item(32'h00000001, 32'h80000000, 0);
        offer_item(32'hffffffff, 32'h00000002, 32'hffffffff);
        offer_item(32'h7fffffff, 0, 32'h80000000);
        offer_item(32'hffffffff, 32'hffffffff, 32'hffffffff);
        offer_item(32'h00020000, 32'h00040000, 32'h00020000);

        // Random: four idling phases over the item stream.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case (i * 4 / RANDOM_ITEMS)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 53; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            if (i % 50 >= 45) begin
                idle_pct = 0;
                stall_pct = 0;
            end
            case ($urandom_range(3))
                0: offer_factored();
                1: offer_item(0, pick_value(), pick_value());
                default: offer_item(pick_value(), pick_value(), pick_value());
            endcase
        end
        coef_valid <= 1'b0;
        stall_pct = 0;

        while (pending != 0) @(posedge clk);
        repeat (120) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
